FILE: rtl/core/fjtoc_pkg.sv
`default_nettype none

package fjtoc_pkg;

  localparam int WORD_W  = 32;
  localparam int TD_W    = 5;
  localparam int DAG_W   = WORD_W - TD_W;
  localparam int LCA_W   = 6;
  localparam int ERR_W   = 2;
  localparam int QDEPTH  = 2;
  localparam logic [WORD_W-1:0] DEPTH_STEP = WORD_W'(33);

  // Request codes as they arrive on in_req_type; REQ_NONE marks unused codes
  typedef enum logic [2:0] {
    REQ_FORK = 3'd0,
    REQ_JOIN = 3'd1,
    REQ_SET  = 3'd2,
    REQ_ORD  = 3'd3,
    REQ_LCA  = 3'd4,
    REQ_NONE = 3'd5
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 2'd0,
    ERR_FORK_DEPTH = 2'd1,
    ERR_JOIN_DEPTH = 2'd2
  } err_t;

  typedef enum logic {
    BK_IDLE,
    BK_FINISH
  } bk_state_t;

  // Classified request as queued between front and back
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] path_a;
    logic [WORD_W-1:0] depth_a;
    logic [WORD_W-1:0] npath_a;
    logic [WORD_W-1:0] npath_b;
    logic [TD_W-1:0]   tdepth_b;
    logic              join_bad;
    logic [TD_W-1:0]   join_td;
    logic [DAG_W-1:0]  join_dd;
  } qitem_t;

  typedef struct packed {
    logic [WORD_W-1:0] left_path;
    logic [WORD_W-1:0] left_depth;
    logic [WORD_W-1:0] right_path;
    logic [WORD_W-1:0] right_depth;
    logic              is_ordered;
    logic [LCA_W-1:0]  lca_heap_depth;
    err_t              error_code;
  } res_t;

  // Keep path bits 0 .. tree depth
  function automatic logic [WORD_W-1:0] npath(input logic [WORD_W-1:0] p,
                                              input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] mask;
    mask = ~(({WORD_W{1'b1}} << d[TD_W-1:0]) << 1);
    return p & mask;
  endfunction

  // Lowest differing bit inside the shared prefix, else the bit just above it
  function automatic logic [WORD_W-1:0] lca_bit(input logic [WORD_W-1:0] p1,
                                                input logic [TD_W-1:0]   t1,
                                                input logic [WORD_W-1:0] p2,
                                                input logic [TD_W-1:0]   t2);
    logic [WORD_W-1:0] sm;
    logic [WORD_W-1:0] x;
    sm = ~({WORD_W{1'b1}} << t1) & ~({WORD_W{1'b1}} << t2);
    x  = ((p1 ^ p2) & sm) | (sm + WORD_W'(1));
    return x & (~x + WORD_W'(1));
  endfunction

  function automatic logic [TD_W-1:0] onehot_index(input logic [WORD_W-1:0] v);
    logic [TD_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) idx = idx | TD_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fjtoc_front.sv
`default_nettype none

module fjtoc_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_req_type,
  input  wire logic [fjtoc_pkg::WORD_W-1:0]  in_path_a,
  input  wire logic [fjtoc_pkg::WORD_W-1:0]  in_depth_a,
  input  wire logic [fjtoc_pkg::WORD_W-1:0]  in_path_b,
  input  wire logic [fjtoc_pkg::WORD_W-1:0]  in_depth_b,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output fjtoc_pkg::qitem_t                  push_item
);

  logic [fjtoc_pkg::TD_W-1:0]  td_a;
  logic [fjtoc_pkg::TD_W-1:0]  td_b;
  logic [fjtoc_pkg::DAG_W-1:0] dag_a;
  logic [fjtoc_pkg::DAG_W-1:0] dag_b;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign td_a  = in_depth_a[fjtoc_pkg::TD_W-1:0];
  assign td_b  = in_depth_b[fjtoc_pkg::TD_W-1:0];
  assign dag_a = in_depth_a[fjtoc_pkg::WORD_W-1:fjtoc_pkg::TD_W];
  assign dag_b = in_depth_b[fjtoc_pkg::WORD_W-1:fjtoc_pkg::TD_W];

  always_comb begin
    case (in_req_type)
      fjtoc_pkg::REQ_FORK: push_item.op = fjtoc_pkg::REQ_FORK;
      fjtoc_pkg::REQ_JOIN: push_item.op = fjtoc_pkg::REQ_JOIN;
      fjtoc_pkg::REQ_SET:  push_item.op = fjtoc_pkg::REQ_SET;
      fjtoc_pkg::REQ_ORD:  push_item.op = fjtoc_pkg::REQ_ORD;
      fjtoc_pkg::REQ_LCA:  push_item.op = fjtoc_pkg::REQ_LCA;
      default:             push_item.op = fjtoc_pkg::REQ_NONE;
    endcase
    push_item.path_a   = in_path_a;
    push_item.depth_a  = in_depth_a;
    push_item.npath_a  = fjtoc_pkg::npath(in_path_a, in_depth_a);
    push_item.npath_b  = fjtoc_pkg::npath(in_path_b, in_depth_b);
    push_item.tdepth_b = td_b;
    // Join merges siblings: same nonzero tree depth, one level up
    push_item.join_bad = (td_a != td_b) || (td_a == '0);
    push_item.join_td  = td_a - fjtoc_pkg::TD_W'(1);
    push_item.join_dd  = ((dag_a > dag_b) ? dag_a : dag_b) + fjtoc_pkg::DAG_W'(1);
  end

endmodule

`default_nettype wire

FILE: rtl/core/fjtoc_queue.sv
`default_nettype none

module fjtoc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire fjtoc_pkg::qitem_t  push_item,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output fjtoc_pkg::qitem_t       pop_item
);

  localparam int PW = (fjtoc_pkg::QDEPTH > 1) ? $clog2(fjtoc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(fjtoc_pkg::QDEPTH + 1);

  fjtoc_pkg::qitem_t ent_r [fjtoc_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != CW'(fjtoc_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(fjtoc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(fjtoc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (!do_push && do_pop) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

FILE: rtl/core/fjtoc_back.sv
`default_nettype none

module fjtoc_back #(
  parameter int LEVELS         = 32,
  parameter int MAX_TREE_DEPTH = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire fjtoc_pkg::qitem_t             q_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fjtoc_pkg::res_t                    out_res
);

  localparam int IW = $clog2(LEVELS);

  typedef struct packed {
    logic                          is_lca;
    logic                          eq;
    logic                          on_path;
    logic [fjtoc_pkg::WORD_W-1:0]  lb;
    logic [fjtoc_pkg::DAG_W-1:0]   dag;
    logic [fjtoc_pkg::TD_W-1:0]    tda;
  } s1_t;

  fjtoc_pkg::bk_state_t          state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  fjtoc_pkg::res_t               res_r, res_nxt;
  s1_t                           s1_r, s1_nxt;
  logic [fjtoc_pkg::WORD_W-1:0]  cur_path_r, cur_path_nxt;
  logic [fjtoc_pkg::WORD_W-1:0]  cur_depth_r, cur_depth_nxt;
  logic [fjtoc_pkg::DAG_W-1:0]   tbl_r [LEVELS];
  logic [LEVELS-1:0]             tbl_vld_r;

  logic                          tbl_we;
  logic [fjtoc_pkg::TD_W-1:0]    tbl_idx;
  logic [fjtoc_pkg::DAG_W-1:0]   tbl_wdata;
  logic                          out_free;
  logic [fjtoc_pkg::TD_W-1:0]    h;
  logic [fjtoc_pkg::WORD_W-1:0]  p1;
  logic [fjtoc_pkg::WORD_W-1:0]  p2;
  logic [fjtoc_pkg::TD_W-1:0]    t2;
  logic [fjtoc_pkg::WORD_W-1:0]  lb;
  logic [fjtoc_pkg::TD_W-1:0]    llen;
  logic [fjtoc_pkg::DAG_W-1:0]   tbl_rd;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_free  = !out_valid_r || out_ready;
  assign h         = cur_depth_r[fjtoc_pkg::TD_W-1:0];

  // Stage one of ordered and lca: locate the lowest differing prefix bit
  assign p1 = q_item.npath_a;
  assign p2 = (q_item.op == fjtoc_pkg::REQ_ORD) ? fjtoc_pkg::npath(cur_path_r, cur_depth_r)
                                                : q_item.npath_b;
  assign t2 = (q_item.op == fjtoc_pkg::REQ_ORD) ? h : q_item.tdepth_b;
  assign lb = fjtoc_pkg::lca_bit(p1, q_item.depth_a[fjtoc_pkg::TD_W-1:0], p2, t2);

  // Stage two: encode the bit and read the sync-depth table at that level
  assign llen   = fjtoc_pkg::onehot_index(s1_r.lb);
  assign tbl_rd = (32'(llen) < LEVELS && tbl_vld_r[llen[IW-1:0]]) ? tbl_r[llen[IW-1:0]] : '0;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    s1_nxt        = s1_r;
    cur_path_nxt  = cur_path_r;
    cur_depth_nxt = cur_depth_r;
    tbl_we        = 1'b0;
    tbl_idx       = q_item.join_td;
    tbl_wdata     = q_item.join_dd;
    q_ready       = (state_r == fjtoc_pkg::BK_IDLE) && out_free;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      fjtoc_pkg::BK_IDLE: begin
        if (q_valid && q_ready) begin
          res_nxt            = '0;
          res_nxt.error_code = fjtoc_pkg::ERR_OK;
          case (q_item.op)
            fjtoc_pkg::REQ_FORK: begin
              out_valid_nxt = 1'b1;
              if (32'(h) >= MAX_TREE_DEPTH) begin
                res_nxt.error_code = fjtoc_pkg::ERR_FORK_DEPTH;
              end else begin
                res_nxt.left_path   = (cur_path_r & ~(fjtoc_pkg::WORD_W'(1) << h)) |
                                      (fjtoc_pkg::WORD_W'(1) << (h + fjtoc_pkg::TD_W'(1)));
                res_nxt.right_path  = cur_path_r | (fjtoc_pkg::WORD_W'(1) << h) |
                                      (fjtoc_pkg::WORD_W'(1) << (h + fjtoc_pkg::TD_W'(1)));
                res_nxt.left_depth  = cur_depth_r + fjtoc_pkg::DEPTH_STEP;
                res_nxt.right_depth = cur_depth_r + fjtoc_pkg::DEPTH_STEP;
              end
            end
            fjtoc_pkg::REQ_JOIN: begin
              out_valid_nxt = 1'b1;
              if (q_item.join_bad) begin
                res_nxt.error_code = fjtoc_pkg::ERR_JOIN_DEPTH;
              end else begin
                cur_path_nxt  = q_item.path_a | (fjtoc_pkg::WORD_W'(1) << q_item.join_td);
                cur_depth_nxt = {q_item.join_dd, q_item.join_td};
                tbl_we        = 1'b1;
              end
            end
            fjtoc_pkg::REQ_SET: begin
              out_valid_nxt = 1'b1;
              cur_path_nxt  = q_item.path_a;
              cur_depth_nxt = q_item.depth_a;
              tbl_we        = 1'b1;
              tbl_idx       = q_item.depth_a[fjtoc_pkg::TD_W-1:0];
              tbl_wdata     = q_item.depth_a[fjtoc_pkg::WORD_W-1:fjtoc_pkg::TD_W];
            end
            fjtoc_pkg::REQ_ORD, fjtoc_pkg::REQ_LCA: begin
              s1_nxt.is_lca  = (q_item.op == fjtoc_pkg::REQ_LCA);
              s1_nxt.eq      = (p1 == p2);
              s1_nxt.on_path = (p1 == ((p1 & (lb - fjtoc_pkg::WORD_W'(1))) | lb));
              s1_nxt.lb      = lb;
              s1_nxt.dag     = q_item.depth_a[fjtoc_pkg::WORD_W-1:fjtoc_pkg::TD_W];
              s1_nxt.tda     = q_item.depth_a[fjtoc_pkg::TD_W-1:0];
              state_nxt      = fjtoc_pkg::BK_FINISH;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      fjtoc_pkg::BK_FINISH: begin
        if (out_free) begin
          res_nxt            = '0;
          res_nxt.error_code = fjtoc_pkg::ERR_OK;
          if (s1_r.is_lca) begin
            res_nxt.lca_heap_depth = s1_r.eq ?
              ({1'b0, s1_r.tda} + fjtoc_pkg::LCA_W'(1)) :
              ({1'b0, llen} + fjtoc_pkg::LCA_W'(1));
          end else begin
            res_nxt.is_ordered = s1_r.eq || s1_r.on_path || (s1_r.dag <= tbl_rd);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = fjtoc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = fjtoc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fjtoc_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      cur_path_r  <= fjtoc_pkg::WORD_W'(1);
      cur_depth_r <= '0;
      tbl_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_path_r  <= cur_path_nxt;
      cur_depth_r <= cur_depth_nxt;
      if (tbl_we && 32'(tbl_idx) < LEVELS) tbl_vld_r[tbl_idx[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    s1_r  <= s1_nxt;
    if (tbl_we && 32'(tbl_idx) < LEVELS) tbl_r[tbl_idx[IW-1:0]] <= tbl_wdata;
  end

endmodule

`default_nettype wire

FILE: rtl/core/fork_join_task_order_checker_top.sv
// Fork-join task order checker.
// Tracks the task identifier (path word, depth word) of one thread plus a
// per-level table of synchronization dag depths, and answers one request at
// a time: fork, join, set, ordered check and lca heap depth.
// Channels: in_* carries a request under in_valid/in_ready, out_* carries
// exactly one result per request under out_valid/out_ready, in order.
// The front decodes each request and precomputes everything that does not
// depend on the thread state (join depths, normalized paths), then pushes it
// into a two-entry queue; the back executes it against the state and holds
// the result in an output register.
// Path: fork, join, set and unused codes pass the queue and the output
// register; ordered and lca also pass a prefix-bit stage and a table-read
// stage in the back, which takes no new request until their answer is out.
// Throughput: one request per cycle for fork/join/set while out_ready stays
// high; the back unit sets it.
// Reset: identifier returns to path 1, depth 0, and the sync-depth table
// reads zero at once (per-level valid bits), so requests are taken the cycle
// after reset releases.
// Receiver stall: the output register holds its result; the queue still
// takes up to two more requests before in_ready drops.
`default_nettype none

module fork_join_task_order_checker_top #(
  parameter int LEVELS         = 32,
  parameter int MAX_TREE_DEPTH = 31
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   in_req_type,
  input  wire logic [31:0]  in_path_a,
  input  wire logic [31:0]  in_depth_a,
  input  wire logic [31:0]  in_path_b,
  input  wire logic [31:0]  in_depth_b,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       out_left_path,
  output logic [31:0]       out_left_depth,
  output logic [31:0]       out_right_path,
  output logic [31:0]       out_right_depth,
  output logic              out_is_ordered,
  output logic [5:0]        out_lca_heap_depth,
  output logic [1:0]        out_error_code
);

  logic              push_valid;
  logic              push_ready;
  fjtoc_pkg::qitem_t push_item;
  logic              pop_valid;
  logic              pop_ready;
  fjtoc_pkg::qitem_t pop_item;
  fjtoc_pkg::res_t   res;

  // Decode and classify
  fjtoc_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_path_a   (in_path_a),
    .in_depth_a  (in_depth_a),
    .in_path_b   (in_path_b),
    .in_depth_b  (in_depth_b),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  // Decouple front from back
  fjtoc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Execute against thread state and the sync-depth table
  fjtoc_back #(
    .LEVELS         (LEVELS),
    .MAX_TREE_DEPTH (MAX_TREE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_item    (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_left_path      = res.left_path;
  assign out_left_depth     = res.left_depth;
  assign out_right_path     = res.right_path;
  assign out_right_depth    = res.right_depth;
  assign out_is_ordered     = res.is_ordered;
  assign out_lca_heap_depth = res.lca_heap_depth;
  assign out_error_code     = res.error_code;

endmodule

`default_nettype wire

FILE: rtl/core/fjtoc_checker.sv
`default_nettype none

module fjtoc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [31:0]  out_left_path,
  input wire logic [31:0]  out_left_depth,
  input wire logic [31:0]  out_right_path,
  input wire logic [31:0]  out_right_depth,
  input wire logic         out_is_ordered,
  input wire logic [5:0]   out_lca_heap_depth,
  input wire logic [1:0]   out_error_code
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_path) &&
      $stable(out_left_depth) && $stable(out_is_ordered) &&
      $stable(out_lca_heap_depth) && $stable(out_error_code))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // An error result carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != 2'd0 |-> out_left_path == '0 &&
      out_right_path == '0 && out_left_depth == '0 && out_right_depth == '0 &&
      !out_is_ordered && out_lca_heap_depth == '0)
    else $error("error result with payload");

  // Fork children share one depth word; ordered and lca answers exclude fork data
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_depth == out_right_depth &&
      ((!out_is_ordered && out_lca_heap_depth == '0) || out_left_path == '0))
    else $error("mixed result kinds");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code != 2'd3 && out_lca_heap_depth <= 6'd32)
    else $error("result field out of range");

endmodule

bind fork_join_task_order_checker_top fjtoc_checker u_fjtoc_checker (.*);

`default_nettype wire

FILE: bench/fjtoc_result_check.sv
`default_nettype none

module fjtoc_result_check
  import fjtoc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_path_a,
  input  wire logic [31:0] in_depth_a,
  input  wire logic [31:0] in_path_b,
  input  wire logic [31:0] in_depth_b,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_left_path,
  input  wire logic [31:0] out_left_depth,
  input  wire logic [31:0] out_right_path,
  input  wire logic [31:0] out_right_depth,
  input  wire logic        out_is_ordered,
  input  wire logic [5:0]  out_lca_heap_depth,
  input  wire logic [1:0]  out_error_code,
  output int               mismatches,
  output int               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREE_LEVELS  = 32;
  localparam int DEEPEST_FORK = 31;

  logic [WORD_W-1:0] thread_path;
  logic [WORD_W-1:0] thread_depth;
  logic [DAG_W-1:0]  sync_dag [TREE_LEVELS];
  res_t              results_due [$];
  int                fail_tally;

  // Path bits 0 .. tree depth; tree depth 31 keeps the whole word
  function automatic logic [WORD_W-1:0] prefix_of(input logic [WORD_W-1:0] p,
                                                  input logic [WORD_W-1:0] d);
    logic [WORD_W:0] keep;
    keep = (33'd1 << (d[TD_W-1:0] + 6'd1)) - 33'd1;
    return p & keep[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] split_bit(input logic [WORD_W-1:0] p1,
                                                  input logic [TD_W-1:0]   t1,
                                                  input logic [WORD_W-1:0] p2,
                                                  input logic [TD_W-1:0]   t2);
    logic [WORD_W-1:0] shared;
    logic [WORD_W-1:0] x;
    shared = ((32'd1 << t1) - 32'd1) & ((32'd1 << t2) - 32'd1);
    x      = ((p1 ^ p2) & shared) | (shared + 32'd1);
    return x & (32'd0 - x);
  endfunction

  // Lowest set bit among 0..30, else 31
  function automatic logic [TD_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [TD_W-1:0] idx;
    idx = TD_W'(WORD_W - 1);
    for (int i = WORD_W - 2; i >= 0; i--) begin
      if (v[i]) idx = TD_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [WORD_W-1:0] sync_read(input logic [TD_W-1:0] idx);
    return (int'(idx) < TREE_LEVELS) ? WORD_W'(sync_dag[idx]) : '0;
  endfunction

  task automatic record_sync(input logic [TD_W-1:0] idx, input logic [WORD_W-1:0] dag);
    if (int'(idx) < TREE_LEVELS) sync_dag[idx] = dag[DAG_W-1:0];
  endtask

  // Advance the thread identifier by one request and queue its result
  task automatic apply_request(input logic [2:0]        req,
                               input logic [WORD_W-1:0] pa,
                               input logic [WORD_W-1:0] da,
                               input logic [WORD_W-1:0] pb,
                               input logic [WORD_W-1:0] db);
    res_t              r;
    logic [TD_W-1:0]   h;
    logic [TD_W-1:0]   td;
    logic [WORD_W-1:0] g1;
    logic [WORD_W-1:0] g2;
    logic [WORD_W-1:0] dd;
    logic [WORD_W-1:0] p1;
    logic [WORD_W-1:0] p2;
    logic [WORD_W-1:0] lb;
    logic [WORD_W-1:0] lpath;
    r = '0;
    case (req)
      REQ_FORK: begin
        h = thread_depth[TD_W-1:0];
        if (h >= TD_W'(DEEPEST_FORK)) begin
          r.error_code = ERR_FORK_DEPTH;
        end else begin
          r.left_path   = (thread_path & ~(32'd1 << h)) | (32'd1 << (h + 5'd1));
          r.left_depth  = thread_depth + DEPTH_STEP;
          r.right_path  = thread_path | (32'd1 << h) | (32'd1 << (h + 5'd1));
          r.right_depth = r.left_depth;
        end
      end
      REQ_JOIN: begin
        if (da[TD_W-1:0] != db[TD_W-1:0] || da[TD_W-1:0] == '0) begin
          r.error_code = ERR_JOIN_DEPTH;
        end else begin
          td           = da[TD_W-1:0] - 5'd1;
          g1           = da >> TD_W;
          g2           = db >> TD_W;
          dd           = ((g1 > g2) ? g1 : g2) + 32'd1;
          thread_path  = pa | (32'd1 << td);
          thread_depth = (dd << TD_W) + WORD_W'(td);
          record_sync(td, dd);
        end
      end
      REQ_SET: begin
        thread_path  = pa;
        thread_depth = da;
        record_sync(da[TD_W-1:0], da >> TD_W);
      end
      REQ_ORD: begin
        p1           = prefix_of(pa, da);
        p2           = prefix_of(thread_path, thread_depth);
        r.is_ordered = 1'b1;
        if (p1 != p2) begin
          lb    = split_bit(p1, da[TD_W-1:0], p2, thread_depth[TD_W-1:0]);
          lpath = (p1 & (lb - 32'd1)) | lb;
          r.is_ordered = (p1 == lpath) || ((da >> TD_W) <= sync_read(lowest_set(lb)));
        end
      end
      REQ_LCA: begin
        p1 = prefix_of(pa, da);
        p2 = prefix_of(pb, db);
        if (p1 == p2) begin
          r.lca_heap_depth = LCA_W'(da[TD_W-1:0]) + 6'd1;
        end else begin
          lb = split_bit(p1, da[TD_W-1:0], p2, db[TD_W-1:0]);
          r.lca_heap_depth = LCA_W'(lowest_set(lb)) + 6'd1;
        end
      end
      default: begin
      end
    endcase
    results_due.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      thread_path  = 32'd1;
      thread_depth = '0;
      for (int i = 0; i < TREE_LEVELS; i++) sync_dag[i] = '0;
      results_due.delete();
      fail_tally = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_tally++;
        end else begin
          want = results_due.pop_front();
          check_field("left_path", want.left_path, out_left_path);
          check_field("left_depth", want.left_depth, out_left_depth);
          check_field("right_path", want.right_path, out_right_path);
          check_field("right_depth", want.right_depth, out_right_depth);
          check_field("is_ordered", 32'(want.is_ordered), 32'(out_is_ordered));
          check_field("lca_heap_depth", 32'(want.lca_heap_depth),
                      32'(out_lca_heap_depth));
          check_field("error_code", 32'(want.error_code), 32'(out_error_code));
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_req_type, in_path_a, in_depth_a, in_path_b, in_depth_b);
      end
    end
    mismatches   <= fail_tally;
    results_owed <= results_due.size();
  end

endmodule

`default_nettype wire

FILE: bench/fork_join_task_order_checker_top_test.sv
`default_nettype none

module fork_join_task_order_checker_top_test;
  import fjtoc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 7;
  localparam int IDLE_PCT        = 27;
  localparam int RANDOM_REQUESTS = 1930;
  localparam int CALM_FIRST      = 900;
  localparam int CALM_LAST       = 1200;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 400000;

  // One task identifier as the generator tracks it
  typedef struct packed {
    logic [31:0] path;
    logic [31:0] depth;
  } tid_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_path_a = '0;
  logic [31:0] in_depth_a = '0;
  logic [31:0] in_path_b = '0;
  logic [31:0] in_depth_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_left_path;
  logic [31:0] out_left_depth;
  logic [31:0] out_right_path;
  logic [31:0] out_right_depth;
  logic        out_is_ordered;
  logic [5:0]  out_lca_heap_depth;
  logic [1:0]  out_error_code;

  int          mismatches;
  int          results_owed;
  int          sent_count = 0;
  int          cycle_count = 0;
  logic        calm;
  tid_t        id_pool [$];

  always #5 clk = ~clk;

  fork_join_task_order_checker_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_path_a          (in_path_a),
    .in_depth_a         (in_depth_a),
    .in_path_b          (in_path_b),
    .in_depth_b         (in_depth_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_path      (out_left_path),
    .out_left_depth     (out_left_depth),
    .out_right_path     (out_right_path),
    .out_right_depth    (out_right_depth),
    .out_is_ordered     (out_is_ordered),
    .out_lca_heap_depth (out_lca_heap_depth),
    .out_error_code     (out_error_code)
  );

  // Watch both channels, predict every result and count mismatches
  fjtoc_result_check i_result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_path_a          (in_path_a),
    .in_depth_a         (in_depth_a),
    .in_path_b          (in_path_b),
    .in_depth_b         (in_depth_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_path      (out_left_path),
    .out_left_depth     (out_left_depth),
    .out_right_path     (out_right_path),
    .out_right_depth    (out_right_depth),
    .out_is_ordered     (out_is_ordered),
    .out_lca_heap_depth (out_lca_heap_depth),
    .out_error_code     (out_error_code),
    .mismatches         (mismatches),
    .results_owed       (results_owed)
  );

  // Hold both sides busy without gaps over a stretch of the random requests
  assign calm = (sent_count >= CALM_FIRST) && (sent_count < CALM_LAST);

  // Stall the result side at random; sent_count only moves at rising edges,
  // so reading it here at the falling edge is race free
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Drive one request at the falling edge, after an optional random gap, and
  // hold it until the block takes it at a rising edge. valid stays high into
  // the next request when there is no gap, so it is never lowered and raised
  // in the same step.
  task automatic issue(input logic [2:0] req, input logic [31:0] pa,
                       input logic [31:0] da, input logic [31:0] pb,
                       input logic [31:0] db);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_path_a   <= pa;
    in_depth_a  <= da;
    in_path_b   <= pb;
    in_depth_b  <= db;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  // Build a well-formed identifier at tree depth td that shares its low path
  // bits with base: copy the common prefix, randomize the bits between, set
  // the marker bit at td and clear everything above. Keep dag depths small so
  // ordered checks land on both sides of the sync-depth table entries.
  function automatic tid_t relative_of(input tid_t base, input int unsigned td);
    tid_t        r;
    int unsigned common;
    logic [31:0] low_mask;
    common   = (base.depth[4:0] < td) ? base.depth[4:0] : td;
    low_mask = (32'd1 << common) - 32'd1;
    r.path   = (base.path & low_mask) | ($urandom() & ~low_mask);
    r.path   = (r.path & ((32'd1 << td) - 32'd1)) | (32'd1 << td);
    r.depth  = {27'($urandom_range(0, 12)), 5'(td)};
    return r;
  endfunction

  // Remember identifiers the thread moves to, so later requests share paths
  task automatic remember(input tid_t id);
    id_pool.push_back(id);
    if (id_pool.size() > 16) void'(id_pool.pop_front());
  endtask

  // Give up once the run is far beyond anything a correct block needs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tid_t        base;
    tid_t        a;
    tid_t        b;
    int unsigned sel;
    int unsigned td;

    id_pool.push_back({32'd1, 32'd0});

    // Hold reset, then release it at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: start from the reset identifier (path 1, depth 0)
    issue(REQ_ORD, 32'd1, 32'd0, 32'd0, 32'd0);
    issue(REQ_LCA, 32'd0, 32'd0, 32'd0, 32'd0);
    issue(REQ_LCA, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    issue(REQ_LCA, 32'hffff_ffff, 32'h0000_001e, 32'h7fff_ffff, 32'h0000_001f);
    issue(REQ_FORK, 32'd0, 32'd0, 32'd0, 32'd0);
    // Move to the deepest tree level with the largest dag depth, then fork
    // past the maximum tree depth
    issue(REQ_SET, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
    issue(REQ_FORK, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    issue(REQ_ORD, 32'h7fff_ffff, 32'h0000_001e, 32'd0, 32'd0);
    issue(REQ_ORD, 32'd0, 32'hffff_ffe0, 32'd0, 32'd0);
    // Join with mismatched tree depths, then with both at zero
    issue(REQ_JOIN, 32'd0, 32'h0000_0003, 32'd0, 32'h0000_0004);
    issue(REQ_JOIN, 32'hffff_ffff, 32'hffff_ffe0, 32'hffff_ffff, 32'hffff_ffe0);
    // Join whose new dag depth overflows the depth word
    issue(REQ_JOIN, 32'h0000_0002, 32'hffff_ffe1, 32'h0000_0003, 32'h0000_0021);
    // Unused request codes change nothing
    for (int code = REQ_NONE; code < (1 << $bits(op_t)); code++) begin
      issue(3'(code), $urandom(), $urandom(), $urandom(), $urandom());
    end
    issue(REQ_SET, 32'h0000_002b, 32'h0000_0045, 32'd0, 32'd0);
    issue(REQ_FORK, 32'd0, 32'd0, 32'd0, 32'd0);
    issue(REQ_JOIN, 32'h0000_004b, 32'h0000_0066, 32'h0000_006b, 32'h0000_0046);
    issue(REQ_ORD, 32'h0000_003b, 32'h0000_0065, 32'd0, 32'd0);
    issue(REQ_ORD, 32'h0000_0013, 32'h0000_00a4, 32'd0, 32'd0);
    issue(REQ_LCA, 32'h0000_002b, 32'h0000_0005, 32'h0000_0033, 32'h0000_0007);
    issue(REQ_SET, 32'd1, 32'd0, 32'd0, 32'd0);

    // Random: mostly well-formed identifiers related to recent ones, the rest
    // raw noise over every field and every request code
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      base = id_pool[$urandom_range(0, id_pool.size() - 1)];
      sel  = $urandom_range(0, 99);
      if (sel >= 72) begin
        issue(3'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(), $urandom());
      end else if (sel < 10) begin
        issue(REQ_FORK, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (sel < 22) begin
        // Move the thread; reach the deepest level now and then
        td = ($urandom_range(0, 15) == 0) ? 31 : $urandom_range(0, 30);
        a  = relative_of(base, td);
        issue(REQ_SET, a.path, a.depth, $urandom(), $urandom());
        remember(a);
      end else if (sel < 34) begin
        // Join two siblings one level below the parent
        td = $urandom_range(1, 31);
        a  = relative_of(base, td);
        b  = relative_of(a, td);
        b.path = a.path ^ (32'd1 << (td - 1));
        issue(REQ_JOIN, a.path, a.depth, b.path, b.depth);
        a.path  = a.path | (32'd1 << (td - 1));
        a.depth = {27'($urandom_range(0, 13)), 5'(td - 1)};
        remember(a);
      end else if (sel < 60) begin
        // Ordered check against an identifier near the current one
        if ($urandom_range(0, 4) == 0) begin
          a = base;
          a.depth[31:5] = 27'($urandom_range(0, 14));
        end else begin
          a = relative_of(base, $urandom_range(0, 31));
        end
        issue(REQ_ORD, a.path, a.depth, $urandom(), $urandom());
      end else begin
        a = relative_of(base, $urandom_range(0, 31));
        b = ($urandom_range(0, 5) == 0) ? a : relative_of(a, $urandom_range(0, 31));
        issue(REQ_LCA, a.path, a.depth, b.path, b.depth);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then keep watching for
    // DRAIN_CYCLES to catch anything extra the block might send
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
